/* rtl/core/fpfa_pkg.sv */
// Shared types and constants for the fixed partition fit allocator.
package fpfa_pkg;

    localparam int NUM_PARTITIONS = 16;
    localparam int SIZE_BITS      = 16;
    localparam int IDX_W          = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;

    // Fixed field widths of the request and result channels
    localparam int REQ_TYPE_W = 2;
    localparam int SLOT_W     = 4;
    localparam int VALUE_W    = 16;
    localparam int CHOSEN_W   = 4;
    localparam int POLICY_W   = 2;
    localparam int LIMIT_W    = 5;

    // Request types
    localparam logic [REQ_TYPE_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd2;

    // Fit policies; the unused code acts as first fit
    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

    // Configuration register indexes
    localparam logic REG_FIT_POLICY        = 1'b0;
    localparam logic REG_PARTITIONS_IN_USE = 1'b1;

    // Search candidate handed from cell to cell
    typedef struct packed {
        logic                 found;
        logic [IDX_W-1:0]     idx;
        logic [SIZE_BITS-1:0] size;
    } cand_t;

    // Controls broadcast to every cell
    typedef struct packed {
        logic                 wr_en;
        logic [SLOT_W-1:0]    wr_slot;
        logic [SIZE_BITS-1:0] wr_size;
        logic                 clr;
        logic                 mark;
        logic [IDX_W-1:0]     mark_idx;
        logic [POLICY_W-1:0]  policy;
        logic [LIMIT_W-1:0]   limit;
        logic [SIZE_BITS-1:0] need;
    } cell_ctrl_t;

endpackage

/* rtl/core/fpfa_cell.sv */
// One partition cell: holds a size and a used mark, refines the passing candidate.
module fpfa_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [fpfa_pkg::IDX_W-1:0] cell_idx,
    input  fpfa_pkg::cell_ctrl_t   ctrl,
    input  fpfa_pkg::cand_t        cand_in,
    output fpfa_pkg::cand_t        cand_out,
    output logic                   used_out
);
    import fpfa_pkg::*;

    logic [SIZE_BITS-1:0] size_reg;
    logic                 used_reg;
    cand_t                cand_reg;
    cand_t                cand_next;
    logic                 in_range;
    logic                 eligible;
    logic                 take;

    // Hold the partition size; written by a load request for this slot
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en && (32'(ctrl.wr_slot) == 32'(cell_idx))) begin
            size_reg <= ctrl.wr_size;
        end
    end

    // Track the used mark: clear starts a new run, mark records a grant
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
        end else if (ctrl.clr) begin
            used_reg <= 1'b0;
        end else if (ctrl.mark && (ctrl.mark_idx == cell_idx)) begin
            used_reg <= 1'b1;
        end
    end

    // Decide whether this partition replaces the incoming candidate
    always_comb begin
        in_range  = 32'(cell_idx) < 32'(ctrl.limit);
        eligible  = in_range && !used_reg && (size_reg >= ctrl.need);
        take      = eligible && (!cand_in.found
                    || ((ctrl.policy == POL_BEST)  && (size_reg < cand_in.size))
                    || ((ctrl.policy == POL_WORST) && (size_reg > cand_in.size)));
        cand_next = cand_in;
        if (take) begin
            cand_next.found = 1'b1;
            cand_next.idx   = cell_idx;
            cand_next.size  = size_reg;
        end
    end

    // Advance the candidate to the neighbor
    always_ff @(posedge aclk) begin
        cand_reg <= cand_next;
    end

    assign cand_out = cand_reg;
    assign used_out = used_reg;

endmodule

/* rtl/core/fixed_partition_fit_allocator_top.sv */
// Top level of the fixed partition fit allocator: control, registers and cell chain.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------------------------
//   s_       | in        | s_valid / s_ready  | s_req_type, s_partition_slot, s_size_value
//   m_       | out       | m_valid / m_ready  | m_granted, m_chosen_partition
//   apb      | in        | psel/penable/pready| paddr, pwrite, pwdata, prdata
//
// Load and clear requests need no scan; the result is registered at acceptance.
// An allocate request scans the whole chain: the candidate walks the
// cell chain one cell per cycle, then the grant is marked and the result loaded.
// One request is in work at a time; a waiting result stalls the next request.
// aresetn (synchronous) clears the used marks, configuration registers and control state.
module fixed_partition_fit_allocator_top (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [fpfa_pkg::REQ_TYPE_W-1:0] s_req_type,
    input  logic [fpfa_pkg::SLOT_W-1:0]     s_partition_slot,
    input  logic [fpfa_pkg::VALUE_W-1:0]    s_size_value,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_granted,
    output logic [fpfa_pkg::CHOSEN_W-1:0]   m_chosen_partition,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fpfa_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [IDX_W-1:0]     cnt_reg, cnt_next;
    logic [SIZE_BITS-1:0] need_reg;
    logic [POLICY_W-1:0]  policy_reg;
    logic [LIMIT_W-1:0]   limit_reg;
    logic                 m_valid_reg, m_valid_next;
    logic                 granted_reg, granted_next;
    logic [CHOSEN_W-1:0]  chosen_reg, chosen_next;

    logic                 s_accept;
    logic                 cfg_wr;
    cell_ctrl_t           ctrl;
    cand_t                cand [NUM_PARTITIONS+1];
    logic [NUM_PARTITIONS-1:0] used_vec;
    cand_t                final_cand;

    assign s_accept = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= POL_FIRST;
            limit_reg  <= LIMIT_W'(16);
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_FIT_POLICY:        policy_reg <= pwdata[POLICY_W-1:0];
                REG_PARTITIONS_IN_USE: limit_reg  <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read back
    always_comb begin
        case (paddr[2])
            REG_FIT_POLICY:        prdata = 32'(policy_reg);
            REG_PARTITIONS_IN_USE: prdata = 32'(limit_reg);
            default:               prdata = '0;
        endcase
    end

    // Hold the request size for the scan
    always_ff @(posedge aclk) begin
        if (s_accept && (s_req_type == REQ_ALLOC)) begin
            need_reg <= SIZE_BITS'(s_size_value);
        end
    end

    // Broadcast controls to the cells
    always_comb begin
        ctrl.wr_en    = s_accept && (s_req_type == REQ_LOAD)
                        && (32'(s_partition_slot) < NUM_PARTITIONS);
        ctrl.wr_slot  = s_partition_slot;
        ctrl.wr_size  = SIZE_BITS'(s_size_value);
        ctrl.clr      = s_accept && (s_req_type == REQ_CLEAR);
        ctrl.mark     = (state_reg == ST_DONE) && final_cand.found;
        ctrl.mark_idx = final_cand.idx;
        ctrl.policy   = policy_reg;
        ctrl.limit    = limit_reg;
        ctrl.need     = need_reg;
    end

    // Empty candidate enters the head of the chain
    assign cand[0] = '{found: 1'b0, idx: '0, size: '0};

    genvar g;
    generate
        for (g = 0; g < NUM_PARTITIONS; g++) begin : g_cell
            fpfa_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cell_idx (IDX_W'(g)),
                .ctrl     (ctrl),
                .cand_in  (cand[g]),
                .cand_out (cand[g+1]),
                .used_out (used_vec[g])
            );
        end
    endgenerate

    assign final_cand = cand[NUM_PARTITIONS];

    // Sequence the scan and load the result register
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        granted_next = granted_reg;
        chosen_next  = chosen_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_req_type == REQ_ALLOC) begin
                        state_next = ST_SCAN;
                        cnt_next   = '0;
                    end else begin
                        m_valid_next = 1'b1;
                        granted_next = 1'b0;
                        chosen_next  = '0;
                    end
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + 1'b1;
                if (32'(cnt_reg) == NUM_PARTITIONS - 1) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                state_next   = ST_IDLE;
                m_valid_next = 1'b1;
                granted_next = final_cand.found;
                chosen_next  = final_cand.found ? CHOSEN_W'(final_cand.idx) : '0;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        granted_reg <= granted_next;
        chosen_reg  <= chosen_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_granted          = granted_reg;
    assign m_chosen_partition = chosen_reg;

`ifndef ASSERT_OFF
    // Output register is free for the whole scan
    a_scan_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !m_valid_reg)
        else $error("result pending during scan");

    // A grant leaves the chosen partition marked used
    a_grant_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DONE) && final_cand.found) |=> used_vec[$past(final_cand.idx)])
        else $error("granted partition not marked used");

    // No grant reports partition zero
    a_nogrant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !granted_reg) |-> (chosen_reg == '0))
        else $error("nonzero partition without grant");

    // A granted partition lies inside the searched range
    a_grant_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DONE) && final_cand.found) |-> (32'(final_cand.idx) < 32'(limit_reg)))
        else $error("grant outside searched partitions");
`endif

endmodule
